/* design/sgd_pkg.sv */
// sgd_pkg: shared types and constants of the Shift-JIS / GBK detector.
// Used by every module under design/; depends on nothing.
package sgd_pkg;

  localparam int SCAN_BYTES = 262144;
  localparam int SCAN_W     = $clog2(SCAN_BYTES + 1);
  localparam int CNT_W      = 19;
  localparam int DATA_W     = 8;
  localparam int OUT_W      = 136;   // 2 + 7 * 19 = 135, padded to bytes
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);
  localparam int Q_CW       = $clog2(Q_DEPTH + 1);
  localparam int MIN_CHARS  = 16;

  typedef enum logic [1:0] {
    ENC_UNKNOWN = 2'd0,
    ENC_SJIS    = 2'd1,
    ENC_GBK     = 2'd2
  } enc_t;

  // One classified input item, as it sits in the queue.
  typedef struct packed {
    logic use_byte;      // byte is real and inside the scan window
    logic last;          // end of buffer
    logic s_trail_ok;    // legal Shift-JIS trail
    logic s_hira_trail;  // trail of a hiragana pair
    logic s_kana;        // half-width katakana
    logic s_lead;        // Shift-JIS lead byte
    logic s_bad;         // illegal single byte under Shift-JIS
    logic s_lead82;      // lead of the hiragana block
    logic g_trail_ok;    // legal GBK trail
    logic g_hanzi_trail; // trail of a level-1 hanzi pair
    logic g_lead;        // GBK lead byte
    logic g_bad;         // illegal single byte under GBK
    logic g_lead_hz;     // lead of the level-1 hanzi block
  } ev_t;

  typedef struct packed {
    logic [CNT_W-1:0] sinv;
    logic [CNT_W-1:0] ginv;
    logic [CNT_W-1:0] spair;
    logic [CNT_W-1:0] gpair;
    logic [CNT_W-1:0] hira;
    logic [CNT_W-1:0] kana;
    logic [CNT_W-1:0] hanzi;
  } tally_t;

endpackage

/* design/sjis_gbk_encoding_detector_top.sv */
// Result path: the end-of-buffer (s_tlast) item reaches m_tvalid through the
// queue and a three-deep pipeline of snapshot, flag and output registers; later
// bytes keep streaming. Throughput: one input transfer per cycle, set by the
// back-end parser and tally update, until an end-of-buffer item waiting on a
// full snapshot slot lets the queue fill. Reset: rst is synchronous, active
// high; clears scan count, parsers, tallies, queue and all valid flags.
// No clearing pass is needed. Top level of the Shift-JIS / GBK detector;
// depends on sgd_pkg, sgd_front, sgd_queue, sgd_back and sgd_decide.
module sjis_gbk_encoding_detector_top (
  input  logic         clk,
  input  logic         rst,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tuser,   // [0] has_byte
  input  logic         s_tlast,   // last_item
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // [1:0] encoding, [20:2] sjis_invalid_count, [39:21] gbk_invalid_count,
  // [58:40] sjis_pair_count, [77:59] gbk_pair_count, [96:78] hiragana_count,
  // [115:97] katakana_count, [134:116] hanzi_count, [135] zero
  output logic [sgd_pkg::OUT_W-1:0] m_tdata
);
  import sgd_pkg::*;

  // front -> queue
  ev_t    fr_ev;
  logic   fr_valid, fr_ready;
  // queue -> back
  ev_t    q_ev;
  logic   q_valid, q_ready;
  // back -> decide: tally snapshot per buffer
  tally_t snap;
  logic   snap_valid, snap_ready;
  // decide -> ports
  enc_t   enc;
  tally_t cnt;

  // Front: scan window and byte classification, no buffering of its own.
  sgd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_has   (s_tuser),
    .in_last  (s_tlast),
    .ev_valid (fr_valid),
    .ev_ready (fr_ready),
    .ev       (fr_ev)
  );

  // Queue decouples the front from a back end stalled on a full snapshot slot.
  sgd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_ev     (fr_ev),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_ev    (q_ev)
  );

  // Back: both parsers and the seven saturating tallies.
  sgd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .ev_valid  (q_valid),
    .ev_ready  (q_ready),
    .ev        (q_ev),
    .res_valid (snap_valid),
    .res_ready (snap_ready),
    .res       (snap)
  );

  // Decision pipeline and output register.
  sgd_decide u_decide (
    .clk       (clk),
    .rst       (rst),
    .res_valid (snap_valid),
    .res_ready (snap_ready),
    .res       (snap),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_enc   (enc),
    .out_cnt   (cnt)
  );

  assign m_tdata = {1'b0, cnt.hanzi, cnt.kana, cnt.hira, cnt.gpair, cnt.spair,
                    cnt.ginv, cnt.sinv, enc};

endmodule

/* design/sgd_front.sv */
// sgd_front: accepts input transfers, applies the scan window and
// classifies each byte for both parsers. Depends on sgd_pkg.
module sgd_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [sgd_pkg::DATA_W-1:0] in_byte,
  input  logic                      in_has,
  input  logic                      in_last,
  output logic                      ev_valid,
  input  logic                      ev_ready,
  output sgd_pkg::ev_t              ev
);
  import sgd_pkg::*;

  logic [SCAN_W-1:0] bytes_seen;
  logic [SCAN_W-1:0] bytes_seen_next;
  logic              in_window;
  logic              accept;

  assign in_ready  = ev_ready;
  assign ev_valid  = in_valid;
  assign accept    = in_valid && ev_ready;
  assign in_window = bytes_seen < SCAN_W'(SCAN_BYTES);

  always_comb begin
    ev               = '0;
    ev.use_byte      = in_has && in_window;
    ev.last          = in_last;
    ev.s_trail_ok    = (in_byte >= 8'h40 && in_byte <= 8'h7E) ||
                       (in_byte >= 8'h80 && in_byte <= 8'hFC);
    ev.s_hira_trail  = in_byte >= 8'h9F && in_byte <= 8'hF1;
    ev.s_kana        = in_byte >= 8'hA1 && in_byte <= 8'hDF;
    ev.s_lead        = (in_byte >= 8'h81 && in_byte <= 8'h9F) ||
                       (in_byte >= 8'hE0 && in_byte <= 8'hFC);
    ev.s_bad         = in_byte == 8'h80 || in_byte == 8'hA0 || in_byte >= 8'hFD;
    ev.s_lead82      = in_byte == 8'h82;
    ev.g_trail_ok    = (in_byte >= 8'h40 && in_byte <= 8'h7E) ||
                       (in_byte >= 8'h80 && in_byte <= 8'hFE);
    ev.g_hanzi_trail = in_byte >= 8'hA1 && in_byte <= 8'hFE;
    ev.g_lead        = in_byte >= 8'h81 && in_byte <= 8'hFE;
    ev.g_bad         = in_byte == 8'h80 || in_byte == 8'hFF;
    ev.g_lead_hz     = in_byte >= 8'hB0 && in_byte <= 8'hD7;
  end

  always_comb begin
    bytes_seen_next = bytes_seen;
    if (accept) begin
      if (in_last) begin
        bytes_seen_next = '0;
      end else if (in_has && in_window) begin
        bytes_seen_next = bytes_seen + SCAN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
    end else begin
      bytes_seen <= bytes_seen_next;
    end
  end

endmodule

/* design/sgd_queue.sv */
// sgd_queue: short register FIFO of classified items between front and back.
// Depends on sgd_pkg.
module sgd_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  sgd_pkg::ev_t in_ev,
  output logic         out_valid,
  input  logic         out_ready,
  output sgd_pkg::ev_t out_ev
);
  import sgd_pkg::*;

  ev_t             slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;
  logic            push;
  logic            pop;

  assign in_ready  = count != Q_CW'(Q_DEPTH);
  assign out_valid = count != '0;
  assign out_ev    = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + Q_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + Q_AW'(1);
      unique case ({push, pop})
        2'b10:   count <= count + Q_CW'(1);
        2'b01:   count <= count - Q_CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* design/sgd_back.sv */
// sgd_back: runs both pair parsers and the saturating tallies, and hands a
// snapshot of the tallies onward at the end of each buffer. Depends on sgd_pkg.
module sgd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           ev_valid,
  output logic           ev_ready,
  input  sgd_pkg::ev_t   ev,
  output logic           res_valid,
  input  logic           res_ready,
  output sgd_pkg::tally_t res
);
  import sgd_pkg::*;

  tally_t cnt;
  tally_t cnt_next;
  logic   s_wait, s_wait_next, s_lead82, s_lead82_next;
  logic   g_wait, g_wait_next, g_lead_hz, g_lead_hz_next;
  logic   take;
  logic   i_sinv, i_ginv, i_spair, i_gpair, i_hira, i_kana, i_hanzi;

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v, input logic inc);
    bump = (inc && v != '1) ? v + CNT_W'(1) : v;
  endfunction

  // Only an end-of-buffer item needs the snapshot slot free.
  assign ev_ready = !ev.last || !res_valid || res_ready;
  assign take     = ev_valid && ev_ready;

  always_comb begin
    i_sinv = 1'b0; i_ginv = 1'b0; i_spair = 1'b0; i_gpair = 1'b0;
    i_hira = 1'b0; i_kana = 1'b0; i_hanzi = 1'b0;
    s_wait_next   = s_wait;
    s_lead82_next = s_lead82;
    g_wait_next   = g_wait;
    g_lead_hz_next = g_lead_hz;
    if (ev.use_byte) begin
      if (s_wait) begin
        s_wait_next = 1'b0;
        i_spair     = ev.s_trail_ok;
        i_hira      = ev.s_trail_ok && s_lead82 && ev.s_hira_trail;
        i_sinv      = !ev.s_trail_ok;
      end else if (ev.s_kana) begin
        i_kana = 1'b1;
      end else if (ev.s_lead) begin
        s_wait_next   = 1'b1;
        s_lead82_next = ev.s_lead82;
      end else begin
        i_sinv = ev.s_bad;
      end
      if (g_wait) begin
        g_wait_next = 1'b0;
        i_gpair     = ev.g_trail_ok;
        i_hanzi     = ev.g_trail_ok && g_lead_hz && ev.g_hanzi_trail;
        i_ginv      = !ev.g_trail_ok;
      end else if (ev.g_lead) begin
        g_wait_next    = 1'b1;
        g_lead_hz_next = ev.g_lead_hz;
      end else begin
        i_ginv = ev.g_bad;
      end
    end
    cnt_next.sinv  = bump(cnt.sinv,  i_sinv);
    cnt_next.ginv  = bump(cnt.ginv,  i_ginv);
    cnt_next.spair = bump(cnt.spair, i_spair);
    cnt_next.gpair = bump(cnt.gpair, i_gpair);
    cnt_next.hira  = bump(cnt.hira,  i_hira);
    cnt_next.kana  = bump(cnt.kana,  i_kana);
    cnt_next.hanzi = bump(cnt.hanzi, i_hanzi);
  end

  always_ff @(posedge clk) begin
    if (take && ev.last) begin
      res <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      s_wait    <= 1'b0;
      s_lead82  <= 1'b0;
      g_wait    <= 1'b0;
      g_lead_hz <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_ready) res_valid <= 1'b0;
      if (take) begin
        if (ev.last) begin
          // pending leads are dropped, everything starts over
          cnt       <= '0;
          s_wait    <= 1'b0;
          s_lead82  <= 1'b0;
          g_wait    <= 1'b0;
          g_lead_hz <= 1'b0;
          res_valid <= 1'b1;
        end else begin
          cnt       <= cnt_next;
          s_wait    <= s_wait_next;
          s_lead82  <= s_lead82_next;
          g_wait    <= g_wait_next;
          g_lead_hz <= g_lead_hz_next;
        end
      end
    end
  end

endmodule

/* design/sgd_decide.sv */
// sgd_decide: rate tests by integer cross-multiplication, then the encoding
// choice and the output register. Depends on sgd_pkg.
module sgd_decide (
  input  logic            clk,
  input  logic            rst,
  input  logic            res_valid,
  output logic            res_ready,
  input  sgd_pkg::tally_t res,
  output logic            out_valid,
  input  logic            out_ready,
  output sgd_pkg::enc_t   out_enc,
  output sgd_pkg::tally_t out_cnt
);
  import sgd_pkg::*;

  localparam int SUM_W  = CNT_W + 2;
  localparam int PROD_W = CNT_W + 8;

  typedef struct packed {
    logic few;
    logic s_clean;
    logic s_dirty;
    logic g_clean;
    logic g_dirty;
    logic h_win;
    logic c_win;
  } flags_t;

  flags_t            fl, fl_reg;
  tally_t            cnt_reg;
  logic              st_valid;
  logic              st_ready;
  logic [SUM_W-1:0]  sc, g, si, gi, h, c;
  logic [PROD_W-1:0] s_tot, g_tot, h10, c10;
  enc_t              enc;

  assign st_ready  = !out_valid || out_ready;
  assign res_ready = !st_valid || st_ready;

  always_comb begin
    sc    = SUM_W'(res.spair) + SUM_W'(res.kana);
    g     = SUM_W'(res.gpair);
    si    = SUM_W'(res.sinv);
    gi    = SUM_W'(res.ginv);
    h     = SUM_W'(res.hira);
    c     = SUM_W'(res.hanzi);
    s_tot = PROD_W'(sc) + PROD_W'(si);
    g_tot = PROD_W'(g) + PROD_W'(gi);
    h10   = PROD_W'(h) * PROD_W'(10);
    c10   = PROD_W'(c) * PROD_W'(10);
    fl.few     = sc < SUM_W'(MIN_CHARS) && g < SUM_W'(MIN_CHARS);
    fl.s_clean = sc != '0 && PROD_W'(si) * PROD_W'(100) < s_tot;
    fl.s_dirty = sc == '0 || PROD_W'(si) * PROD_W'(20) > s_tot;
    fl.g_clean = g != '0 && PROD_W'(gi) * PROD_W'(100) < g_tot;
    fl.g_dirty = g == '0 || PROD_W'(gi) * PROD_W'(20) > g_tot;
    // 10h > max(sc, g) split into two compares
    fl.h_win   = h > (c << 1) && h10 > PROD_W'(sc) && h10 > PROD_W'(g);
    fl.c_win   = c > (h << 1) && c10 > PROD_W'(sc) && c10 > PROD_W'(g);
  end

  always_comb begin
    priority if (fl_reg.few) begin
      enc = ENC_UNKNOWN;
    end else if (fl_reg.s_clean && fl_reg.g_dirty) begin
      enc = ENC_SJIS;
    end else if (fl_reg.g_clean && fl_reg.s_dirty) begin
      enc = ENC_GBK;
    end else if (fl_reg.h_win) begin
      enc = ENC_SJIS;
    end else if (fl_reg.c_win) begin
      enc = ENC_GBK;
    end else begin
      enc = ENC_UNKNOWN;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      fl_reg  <= fl;
      cnt_reg <= res;
    end
    if (st_valid && st_ready) begin
      out_enc <= enc;
      out_cnt <= cnt_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (res_ready) st_valid  <= res_valid;
      if (st_ready)  out_valid <= st_valid;
    end
  end

endmodule

/* bench/sjis_gbk_detect_checker.sv */
`timescale 1ns / 100ps
// sjis_gbk_detect_checker: watches the byte and decision streams of the detector,
// predicts every decision transfer and compares it field by field.
// Depends on sgd_pkg for the encoding enum, the counter width and the scan window.
module sjis_gbk_detect_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tuser,   // [0] has_byte
  input  logic         s_tlast,   // last_item
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [135:0] m_tdata,   // encoding, then seven 19-bit counters
  output int           fail_count,
  output int           pending_results
);
  import sgd_pkg::*;

  localparam logic [CNT_W-1:0] CNT_TOP = '1;

  typedef struct {
    logic [CNT_W-1:0] s_inv;
    logic [CNT_W-1:0] g_inv;
    logic [CNT_W-1:0] s_pair;
    logic [CNT_W-1:0] g_pair;
    logic [CNT_W-1:0] hira;
    logic [CNT_W-1:0] kana;
    logic [CNT_W-1:0] hanzi;
  } charset_tally_t;

  string field_name [8] = '{"encoding", "sjis_invalid_count", "gbk_invalid_count",
                            "sjis_pair_count", "gbk_pair_count", "hiragana_count",
                            "katakana_count", "hanzi_count"};

  int unsigned    scanned;
  logic           sj_pend;
  logic [7:0]     sj_lead;
  logic           gb_pend;
  logic [7:0]     gb_lead;
  charset_tally_t cnt;
  logic [135:0]   expected_decisions [$];

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (v == CNT_TOP) ? v : v + 1'b1;
  endfunction

  task automatic clear_scan();
    scanned = 0;
    sj_pend = 1'b0;
    sj_lead = 8'h00;
    gb_pend = 1'b0;
    gb_lead = 8'h00;
    cnt = '{default: '0};
  endtask

  task automatic feed_sjis(logic [7:0] b);
    if (sj_pend) begin
      sj_pend = 1'b0;
      if ((b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFC)) begin
        cnt.s_pair = sat_inc(cnt.s_pair);
        if (sj_lead == 8'h82 && b >= 8'h9F && b <= 8'hF1) cnt.hira = sat_inc(cnt.hira);
      end else begin
        cnt.s_inv = sat_inc(cnt.s_inv);
      end
    end else if (b >= 8'h80) begin
      if (b >= 8'hA1 && b <= 8'hDF) begin
        cnt.kana = sat_inc(cnt.kana);
      end else if ((b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC)) begin
        sj_pend = 1'b1;
        sj_lead = b;
      end else begin
        cnt.s_inv = sat_inc(cnt.s_inv);
      end
    end
  endtask

  task automatic feed_gbk(logic [7:0] b);
    if (gb_pend) begin
      gb_pend = 1'b0;
      if ((b >= 8'h40 && b <= 8'h7E) || (b >= 8'h80 && b <= 8'hFE)) begin
        cnt.g_pair = sat_inc(cnt.g_pair);
        if (gb_lead >= 8'hB0 && gb_lead <= 8'hD7 && b >= 8'hA1 && b <= 8'hFE)
          cnt.hanzi = sat_inc(cnt.hanzi);
      end else begin
        cnt.g_inv = sat_inc(cnt.g_inv);
      end
    end else if (b >= 8'h80) begin
      if (b >= 8'h81 && b <= 8'hFE) begin
        gb_pend = 1'b1;
        gb_lead = b;
      end else begin
        cnt.g_inv = sat_inc(cnt.g_inv);
      end
    end
  endtask

  // Rate tests as integer cross-multiplications: clean below 1%, dirty above 5%.
  function automatic enc_t judge_encoding(charset_tally_t t);
    longint unsigned sc, g, si, gi, h, c, top;
    logic s_clean, s_dirty, g_clean, g_dirty;
    sc = 64'(t.s_pair) + 64'(t.kana);
    g  = 64'(t.g_pair);
    si = 64'(t.s_inv);
    gi = 64'(t.g_inv);
    h  = 64'(t.hira);
    c  = 64'(t.hanzi);
    if (sc < MIN_CHARS && g < MIN_CHARS) return ENC_UNKNOWN;
    s_clean = sc > 0 && 100 * si < sc + si;
    s_dirty = sc == 0 || 20 * si > sc + si;
    g_clean = g > 0 && 100 * gi < g + gi;
    g_dirty = g == 0 || 20 * gi > g + gi;
    if (s_clean && g_dirty) return ENC_SJIS;
    if (g_clean && s_dirty) return ENC_GBK;
    top = (sc > g) ? sc : g;
    if (top > 0) begin
      if (h > 2 * c && 10 * h > top) return ENC_SJIS;
      if (c > 2 * h && 10 * c > top) return ENC_GBK;
    end
    return ENC_UNKNOWN;
  endfunction

  always @(posedge clk) begin : watch
    logic [135:0]     want;
    int               lsb;
    logic [CNT_W-1:0] exp_v, got_v;
    if (rst) begin
      clear_scan();
      expected_decisions.delete();
      fail_count = 0;
    end else begin
      // output side first: a decision never leaves on the edge its byte arrives
      if (m_tvalid && m_tready) begin
        if (expected_decisions.size() == 0) begin
          $error("decision transfer with none expected: %h", m_tdata);
          fail_count++;
        end else begin
          want = expected_decisions.pop_front();
          for (int k = 0; k < 8; k++) begin
            lsb = (k == 0) ? 0 : 2 + (k - 1) * CNT_W;
            if (k == 0) begin
              exp_v = CNT_W'(want[1:0]);
              got_v = CNT_W'(m_tdata[1:0]);
            end else begin
              exp_v = want[lsb +: CNT_W];
              got_v = m_tdata[lsb +: CNT_W];
            end
            if (exp_v !== got_v) begin
              $error("%s: expected %0d, got %0d", field_name[k], exp_v, got_v);
              fail_count++;
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser && scanned < SCAN_BYTES) begin
          scanned++;
          feed_sjis(s_tdata);
          feed_gbk(s_tdata);
        end
        if (s_tlast) begin
          expected_decisions.push_back({1'b0, cnt.hanzi, cnt.kana, cnt.hira, cnt.g_pair,
                                        cnt.s_pair, cnt.g_inv, cnt.s_inv,
                                        judge_encoding(cnt)});
          clear_scan();
        end
      end
    end
    pending_results = expected_decisions.size();
  end

endmodule

/* bench/tb_sjis_gbk_encoding_detector_top.sv */
`timescale 1ns / 100ps
// tb_sjis_gbk_encoding_detector_top: stimulus and verdict for the Shift-JIS / GBK
// detector; needs sgd_pkg, the detector RTL and sjis_gbk_detect_checker.
module tb_sjis_gbk_encoding_detector_top;
  import sgd_pkg::*;

  typedef enum int {TXT_SJIS, TXT_GBK, TXT_NOISE} text_kind_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic [7:0]   s_tdata = 8'h00;
  logic         s_tuser = 1'b0;
  logic         s_tlast = 1'b0;
  logic         m_tready = 1'b0;
  wire          s_tready;
  wire          m_tvalid;
  wire  [135:0] m_tdata;

  int fail_count;
  int pending_results;

  bit         send_steady;   // sender stretch with no gaps
  bit         take_steady;   // receiver stretch with tready held high
  int         items_sent;    // transfers that carry a byte or end a buffer
  logic [7:0] text_q [$];    // bytes of the buffer under construction

  always #5 clk = ~clk;

  sjis_gbk_encoding_detector_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  sjis_gbk_detect_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .s_tlast         (s_tlast),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // One input transfer. Called at a falling edge, returns at a falling edge.
  // With no gap drawn tvalid simply stays high into the next transfer.
  task automatic send_item(logic [7:0] b, logic has, logic last);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = b;
    s_tuser  = has;
    s_tlast  = last;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (has || last) items_sent++;
  endtask

  // Send text_q as one buffer. The end marker either rides on the final byte
  // or follows as a byte-less transfer; byte-less filler is sprinkled in.
  task automatic send_buffer(bit end_on_byte);
    int n;
    n = text_q.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(text_q[i], 1'b1, end_on_byte && i == n - 1);
    end
    if (!end_on_byte || n == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    text_q.delete();
  endtask

  // Build roughly nbytes of text: for SJIS or GBK mostly well-formed characters of
  // that charset with random content and a few stray bytes; TXT_NOISE is random bytes.
  task automatic make_text(text_kind_t kind, int nbytes);
    int r;
    while (text_q.size() < nbytes) begin
      r = (kind == TXT_NOISE) ? 0 : $urandom_range(0, 99);
      if (r < 3) begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end else if (r < 20) begin
        text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));     // ASCII
      end else if (kind == TXT_SJIS) begin
        if (r < 50) begin                                         // hiragana pair
          text_q.push_back(8'h82);
          text_q.push_back(8'($urandom_range(8'h9F, 8'hF1)));
        end else if (r < 65) begin                                // half-width kana
          text_q.push_back(8'($urandom_range(8'hA1, 8'hDF)));
        end else begin                                            // kanji pair
          text_q.push_back(8'($urandom_range(0, 1) ? $urandom_range(8'h81, 8'h9F)
                                                   : $urandom_range(8'hE0, 8'hFC)));
          text_q.push_back(8'($urandom_range(0, 1) ? $urandom_range(8'h40, 8'h7E)
                                                   : $urandom_range(8'h80, 8'hFC)));
        end
      end else begin
        if (r < 65) begin                                         // level-1 hanzi
          text_q.push_back(8'($urandom_range(8'hB0, 8'hD7)));
          text_q.push_back(8'($urandom_range(8'hA1, 8'hFE)));
        end else begin                                            // other GBK pair
          text_q.push_back(8'($urandom_range(8'h81, 8'hFE)));
          text_q.push_back(8'($urandom_range(0, 1) ? $urandom_range(8'h40, 8'h7E)
                                                   : $urandom_range(8'h80, 8'hFE)));
        end
      end
    end
  endtask

  // Result side: a random hold-off before each decision transfer, with
  // stretches where tready never drops.
  initial begin : decision_sink
    int gap, n;
    n = 0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (n % 8 == 0) take_steady = ($urandom_range(0, 3) == 0);
      n++;
      gap = take_steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int k;
    items_sent  = 0;
    send_steady = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty buffer, an ignored filler, range edges of both parsers,
    // a buffer ending on a lead byte, and a pending lead before a byte-less end.
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
    text_q = {8'h00, 8'h7F, 8'h80, 8'hFF, 8'h82, 8'h9F, 8'h82, 8'hF1, 8'hB0, 8'hA1,
              8'hD7, 8'hFE, 8'hA0, 8'hDF, 8'hE0, 8'h40, 8'hFC, 8'h7E, 8'hFD, 8'h3F,
              8'h81, 8'h7F, 8'h81};
    send_buffer(1'b1);
    text_q = {8'h82, 8'hA0, 8'hE0};
    send_buffer(1'b0);

    // Random buffers, mostly well-formed text near the decision thresholds.
    items_sent = 0;
    while (items_sent < 1500) begin
      send_steady = ($urandom_range(0, 3) == 0);
      k = $urandom_range(0, 9);
      if (k < 4)      make_text(TXT_SJIS, $urandom_range(8, 60));
      else if (k < 8) make_text(TXT_GBK, $urandom_range(8, 60));
      else if (k < 9) make_text(TXT_NOISE, $urandom_range(1, 40));
      else            make_text(TXT_NOISE, $urandom_range(0, 2));
      send_buffer($urandom_range(0, 1));
    end
    s_tvalid = 1'b0;

    // drain, then allow for the output pipeline plus sink stalls
    while (pending_results != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin : watchdog
    #(20_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sjis_gbk_encoding_detector_top.f */
design/sgd_pkg.sv
design/sgd_front.sv
design/sgd_queue.sv
design/sgd_back.sv
design/sgd_decide.sv
design/sjis_gbk_encoding_detector_top.sv
bench/sjis_gbk_detect_checker.sv
bench/tb_sjis_gbk_encoding_detector_top.sv
